// File: sv/vertex_position_normal_transform_unit_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the vertex position and normal transform unit
// Shared property forms used by the top module of the block.
// ---------------------------------------------------------------------------
`ifndef VERTEX_POSITION_NORMAL_TRANSFORM_UNIT_ASSERT_SVH
`define VERTEX_POSITION_NORMAL_TRANSFORM_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define VPNT_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("vpnt assertion failed");

// Next-cycle implication, checked outside reset.
`define VPNT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("vpnt assertion failed");

`endif

// File: sv/vpnt_pkg.sv
// ---------------------------------------------------------------------------
// Vertex transform package
// Beat types, register indexes and fixed-point constants of the block.
// ---------------------------------------------------------------------------
package vpnt_pkg;

    localparam int MAT_W      = 16;
    localparam int POS_W      = 32;
    localparam int NRM_W      = 16;
    localparam int COF_W      = 34;
    localparam int ROW_W      = 48;
    localparam int SHIFT_W    = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 48;
    localparam int COF_N      = 9;

    localparam logic [ROW_W-1:0] ROW_X_RESET = 48'h0000_0000_1000;
    localparam logic [ROW_W-1:0] ROW_Y_RESET = 48'h0000_1000_0000;
    localparam logic [ROW_W-1:0] ROW_Z_RESET = 48'h1000_0000_0000;
    localparam logic [COF_W-1:0] COF_ONE     = 34'h001000000;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ROW_X   = 3'd0,
        REG_ROW_Y   = 3'd1,
        REG_ROW_Z   = 3'd2,
        REG_SHIFT_X = 3'd3,
        REG_SHIFT_Y = 3'd4,
        REG_SHIFT_Z = 3'd5
    } cfg_reg_t;

    typedef struct packed {
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic signed [POS_W-1:0] pos_z;
        logic signed [NRM_W-1:0] norm_x;
        logic signed [NRM_W-1:0] norm_y;
        logic signed [NRM_W-1:0] norm_z;
        logic signed [POS_W-1:0] tex_u;
        logic signed [POS_W-1:0] tex_v;
    } vpnt_in_t;

    typedef struct packed {
        logic signed [POS_W-1:0] world_x;
        logic signed [POS_W-1:0] world_y;
        logic signed [POS_W-1:0] world_z;
        logic signed [NRM_W-1:0] unit_x;
        logic signed [NRM_W-1:0] unit_y;
        logic signed [NRM_W-1:0] unit_z;
        logic signed [POS_W-1:0] out_u;
        logic signed [POS_W-1:0] out_v;
        logic                    degenerate_normal;
        logic                    position_clipped;
    } vpnt_out_t;

    typedef struct packed {
        logic busy;
        logic det_neg;
    } cof_status_t;

endpackage

// File: sv/vertex_position_normal_transform_unit.sv
// ---------------------------------------------------------------------------
// Vertex position and normal transform unit
// Transforms the position by the affine model matrix and the normal by the
// cofactor matrix, then brings the normal to unit length.
// ---------------------------------------------------------------------------
//  Channel  Ports                          Beat
//  input    s_valid s_ready s_data         one vertex (vpnt_in_t)
//  output   m_valid m_ready m_data         one transformed vertex (vpnt_out_t)
//  config   cfg_valid cfg_ready cfg_index  one register write (cfg_data)
//
//  One vertex enters per cycle unless a cofactor recompute or a backed-up stall holds it.
//  The depth is set by the square root (32 stages) and the divider (15 stages).
//  A write to a matrix row holds the input while the cofactors
//  are recomputed; reset loads the identity matrix with no recompute.
//  A stall at the output backs up stage by stage and fills empty stages first.
// ---------------------------------------------------------------------------
`include "vertex_position_normal_transform_unit_assert.svh"

module vertex_position_normal_transform_unit (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  vpnt_pkg::vpnt_in_t                  s_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output vpnt_pkg::vpnt_out_t                 m_data,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [vpnt_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [vpnt_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import vpnt_pkg::*;

    localparam int ISQ_N  = 32;
    localparam int DIV_N  = 15;
    localparam int M_W    = 30;
    localparam int MAG_W  = 50;
    localparam int PACC_W = 51;
    localparam int REM_W  = M_W + DIV_N + 2;
    localparam int ST_MUL = 0;
    localparam int ST_SUM = 1;
    localparam int ST_NRM = 2;
    localparam int ST_SHF = 3;
    localparam int ST_SQR = 4;
    localparam int ST_ACC = 5;
    localparam int ST_ISQ = 6;
    localparam int ST_DIV = ST_ISQ + ISQ_N;
    localparam int ST_OUT = ST_DIV + DIV_N;
    localparam int NS     = ST_OUT + 1;

    typedef struct packed {
        logic signed [POS_W-1:0] world_x;
        logic signed [POS_W-1:0] world_y;
        logic signed [POS_W-1:0] world_z;
        logic                    clipped;
        logic signed [POS_W-1:0] tex_u;
        logic signed [POS_W-1:0] tex_v;
        logic                    degen;
        logic [2:0]              neg;
    } side_t;

    typedef struct packed {
        side_t                side;
        logic [2:0][M_W-1:0]  m;
        logic [63:0]          x;
        logic [63:0]          r;
    } isq_t;

    typedef struct packed {
        side_t                  side;
        logic [2:0][REM_W-1:0]  rem;
        logic [2:0][DIV_N-1:0]  q;
        logic [31:0]            d;
    } div_t;

    // Configuration registers and cofactor state
    logic [2:0][ROW_W-1:0]   row_reg;
    logic [2:0][SHIFT_W-1:0] shift_reg;
    logic                    cfg_write;
    logic                    row_write;
    logic [COF_N-1:0][COF_W-1:0] cof;
    cof_status_t             cof_status;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    always_comb begin
        row_write = 1'b0;
        if (cfg_write) begin
            unique case (cfg_index)
                REG_ROW_X, REG_ROW_Y, REG_ROW_Z: row_write = 1'b1;
                default:                         row_write = 1'b0;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_reg[0]   <= ROW_X_RESET;
            row_reg[1]   <= ROW_Y_RESET;
            row_reg[2]   <= ROW_Z_RESET;
            shift_reg[0] <= '0;
            shift_reg[1] <= '0;
            shift_reg[2] <= '0;
        end else if (cfg_write) begin
            unique case (cfg_index)
                REG_ROW_X:   row_reg[0]   <= cfg_data;
                REG_ROW_Y:   row_reg[1]   <= cfg_data;
                REG_ROW_Z:   row_reg[2]   <= cfg_data;
                REG_SHIFT_X: shift_reg[0] <= cfg_data[SHIFT_W-1:0];
                REG_SHIFT_Y: shift_reg[1] <= cfg_data[SHIFT_W-1:0];
                REG_SHIFT_Z: shift_reg[2] <= cfg_data[SHIFT_W-1:0];
                default: ;
            endcase
        end
    end

    vpnt_cofactor u_cofactor (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (row_write),
        .rows    (row_reg),
        .cof     (cof),
        .status  (cof_status)
    );

    // Stage valid bits and backpressure
    logic [NS-1:0] vld_reg, vld_next;
    logic [NS:0]   rdy;
    logic          in_go;

    assign in_go   = s_valid && !cof_status.busy;
    assign s_ready = rdy[ST_MUL] && !cof_status.busy;

    always_comb begin
        rdy[NS] = m_ready;
        for (int k = NS - 1; k >= 0; k--) begin
            rdy[k] = !vld_reg[k] || rdy[k+1];
        end
    end

    assign vld_next = {vld_reg[NS-2:0], in_go};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            for (int k = 0; k < NS; k++) begin
                if (rdy[k]) begin
                    vld_reg[k] <= vld_next[k];
                end
            end
        end
    end

    // Products
    logic signed [POS_W-1:0]       pin [3];
    logic signed [NRM_W-1:0]       nin [3];
    logic signed [MAT_W+POS_W-1:0] pp_reg [3][3];
    logic signed [COF_W+NRM_W-1:0] np_reg [3][3];
    logic signed [POS_W-1:0]       tu0_reg, tv0_reg;

    assign pin[0] = s_data.pos_x;
    assign pin[1] = s_data.pos_y;
    assign pin[2] = s_data.pos_z;
    assign nin[0] = s_data.norm_x;
    assign nin[1] = s_data.norm_y;
    assign nin[2] = s_data.norm_z;

    always_ff @(posedge aclk) begin
        if (rdy[ST_MUL]) begin
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    pp_reg[i][j] <= $signed(row_reg[i][j*MAT_W +: MAT_W]) * pin[j];
                    np_reg[i][j] <= $signed(cof[i*3+j]) * nin[j];
                end
            end
            tu0_reg <= s_data.tex_u;
            tv0_reg <= s_data.tex_v;
        end
    end

    // Sums
    logic signed [PACC_W-1:0] pacc_reg [3];
    logic [MAG_W-1:0]         mag1_reg [3];
    logic [2:0]               neg1_reg;
    logic signed [POS_W-1:0]  tu1_reg, tv1_reg;
    logic signed [PACC_W-1:0] pacc_c [3];
    logic signed [MAG_W+2:0]  vsum_c [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            pacc_c[i] = (PACC_W'($signed(shift_reg[i])) <<< 12) + PACC_W'(2048)
                      + PACC_W'(pp_reg[i][0]) + PACC_W'(pp_reg[i][1])
                      + PACC_W'(pp_reg[i][2]);
            vsum_c[i] = (MAG_W+3)'(np_reg[i][0]) + (MAG_W+3)'(np_reg[i][1])
                      + (MAG_W+3)'(np_reg[i][2]);
            if (cof_status.det_neg) begin
                vsum_c[i] = -vsum_c[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy[ST_SUM]) begin
            for (int i = 0; i < 3; i++) begin
                pacc_reg[i] <= pacc_c[i];
                neg1_reg[i] <= vsum_c[i][MAG_W+2];
                mag1_reg[i] <= vsum_c[i][MAG_W+2] ? MAG_W'(-vsum_c[i]) : MAG_W'(vsum_c[i]);
            end
            tu1_reg <= tu0_reg;
            tv1_reg <= tv0_reg;
        end
    end

    // Position rounding and saturation, leading one of the normal
    side_t                    side2_reg, side3_reg, side4_reg, side5_reg;
    logic [MAG_W-1:0]         mag2_reg [3];
    logic [5:0]               lead2_reg;
    logic signed [POS_W-1:0]  world_c [3];
    logic [2:0]               clip_c;
    logic [MAG_W-1:0]         mag_or;
    logic [5:0]               lead_c;
    logic signed [PACC_W-13:0] fl_c [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            fl_c[i] = pacc_reg[i][PACC_W-1:12];
            if (fl_c[i] > (PACC_W-12)'(32'sh7fffffff)) begin
                world_c[i] = 32'sh7fffffff;
                clip_c[i]  = 1'b1;
            end else if (fl_c[i] < -(PACC_W-12)'(33'sh080000000)) begin
                world_c[i] = 32'sh80000000;
                clip_c[i]  = 1'b1;
            end else begin
                world_c[i] = fl_c[i][POS_W-1:0];
                clip_c[i]  = 1'b0;
            end
        end
        mag_or = mag1_reg[0] | mag1_reg[1] | mag1_reg[2];
        lead_c = '0;
        for (int b = 0; b < MAG_W; b++) begin
            if (mag_or[b]) begin
                lead_c = 6'(b);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy[ST_NRM]) begin
            side2_reg.world_x <= world_c[0];
            side2_reg.world_y <= world_c[1];
            side2_reg.world_z <= world_c[2];
            side2_reg.clipped <= |clip_c;
            side2_reg.tex_u   <= tu1_reg;
            side2_reg.tex_v   <= tv1_reg;
            side2_reg.degen   <= (mag_or == '0);
            side2_reg.neg     <= neg1_reg;
            lead2_reg         <= lead_c;
            for (int i = 0; i < 3; i++) begin
                mag2_reg[i] <= mag1_reg[i];
            end
        end
    end

    // Normalizing shift
    logic [2:0][M_W-1:0] m3_reg, m4_reg, m5_reg;
    logic [M_W-1:0]      msh_c [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            if (lead2_reg > 6'(M_W-1)) begin
                msh_c[i] = M_W'(mag2_reg[i] >> (lead2_reg - 6'(M_W-1)));
            end else begin
                msh_c[i] = M_W'(mag2_reg[i] << (6'(M_W-1) - lead2_reg));
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy[ST_SHF]) begin
            side3_reg <= side2_reg;
            for (int i = 0; i < 3; i++) begin
                m3_reg[i] <= msh_c[i];
            end
        end
    end

    // Squares and their sum
    logic [2*M_W-1:0] sq_reg [3];
    logic [63:0]      sum_reg;

    always_ff @(posedge aclk) begin
        if (rdy[ST_SQR]) begin
            side4_reg <= side3_reg;
            m4_reg    <= m3_reg;
            for (int i = 0; i < 3; i++) begin
                sq_reg[i] <= m3_reg[i] * m3_reg[i];
            end
        end
        if (rdy[ST_ACC]) begin
            side5_reg <= side4_reg;
            m5_reg    <= m4_reg;
            sum_reg   <= 64'(sq_reg[0]) + 64'(sq_reg[1]) + 64'(sq_reg[2]);
        end
    end

    // Square root, one result bit per stage
    isq_t isq_in  [ISQ_N];
    isq_t isq_reg [ISQ_N];

    for (genvar k = 0; k < ISQ_N; k++) begin : g_isq
        localparam logic [63:0] BIT = 64'd1 << (2 * (ISQ_N - 1 - k));
        logic [63:0] trial;

        if (k == 0) begin : g_first
            always_comb begin
                isq_in[k].side = side5_reg;
                isq_in[k].m    = m5_reg;
                isq_in[k].x    = sum_reg;
                isq_in[k].r    = '0;
            end
        end else begin : g_rest
            assign isq_in[k] = isq_reg[k-1];
        end

        assign trial = isq_in[k].r + BIT;

        always_ff @(posedge aclk) begin
            if (rdy[ST_ISQ+k]) begin
                isq_reg[k].side <= isq_in[k].side;
                isq_reg[k].m    <= isq_in[k].m;
                if (isq_in[k].x >= trial) begin
                    isq_reg[k].x <= isq_in[k].x - trial;
                    isq_reg[k].r <= (isq_in[k].r >> 1) + BIT;
                end else begin
                    isq_reg[k].x <= isq_in[k].x;
                    isq_reg[k].r <= isq_in[k].r >> 1;
                end
            end
        end
    end

    // Restoring division, one quotient bit per stage for all three lanes
    div_t div_in  [DIV_N];
    div_t div_reg [DIV_N];

    for (genvar k = 0; k < DIV_N; k++) begin : g_div
        localparam int QB = DIV_N - 1 - k;
        logic [REM_W-1:0] dsh;

        if (k == 0) begin : g_first
            logic [31:0] len;
            assign len = isq_reg[ISQ_N-1].r[31:0];
            always_comb begin
                div_in[k].side = isq_reg[ISQ_N-1].side;
                div_in[k].d    = {len[30:0], 1'b0};
                div_in[k].q    = '0;
                for (int i = 0; i < 3; i++) begin
                    div_in[k].rem[i] = REM_W'({isq_reg[ISQ_N-1].m[i], {DIV_N{1'b0}}})
                                     + REM_W'(len);
                end
            end
        end else begin : g_rest
            assign div_in[k] = div_reg[k-1];
        end

        assign dsh = REM_W'(div_in[k].d) << QB;

        always_ff @(posedge aclk) begin
            if (rdy[ST_DIV+k]) begin
                div_reg[k].side <= div_in[k].side;
                div_reg[k].d    <= div_in[k].d;
                for (int i = 0; i < 3; i++) begin
                    if (div_in[k].rem[i] >= dsh) begin
                        div_reg[k].rem[i]   <= div_in[k].rem[i] - dsh;
                        div_reg[k].q[i]     <= div_in[k].q[i] | (DIV_N'(1) << QB);
                    end else begin
                        div_reg[k].rem[i]   <= div_in[k].rem[i];
                        div_reg[k].q[i]     <= div_in[k].q[i];
                    end
                end
            end
        end
    end

    // Sign and output register
    vpnt_out_t out_reg;
    div_t      dfin;
    logic signed [NRM_W-1:0] unit_c [3];

    assign dfin = div_reg[DIV_N-1];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            if (dfin.side.degen) begin
                unit_c[i] = '0;
            end else if (dfin.side.neg[i]) begin
                unit_c[i] = -$signed({1'b0, dfin.q[i]});
            end else begin
                unit_c[i] = $signed({1'b0, dfin.q[i]});
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy[ST_OUT]) begin
            out_reg.world_x           <= dfin.side.world_x;
            out_reg.world_y           <= dfin.side.world_y;
            out_reg.world_z           <= dfin.side.world_z;
            out_reg.unit_x            <= unit_c[0];
            out_reg.unit_y            <= unit_c[1];
            out_reg.unit_z            <= unit_c[2];
            out_reg.out_u             <= dfin.side.tex_u;
            out_reg.out_v             <= dfin.side.tex_v;
            out_reg.degenerate_normal <= dfin.side.degen;
            out_reg.position_clipped  <= dfin.side.clipped;
        end
    end

    assign m_valid = vld_reg[ST_OUT];
    assign m_data  = out_reg;

    `VPNT_ASSERT_IMPLY(a_busy_blocks_input, aclk, aresetn, cof_status.busy, !s_ready)
    `VPNT_ASSERT_IMPLY(a_degen_unit_zero, aclk, aresetn,
        m_valid && m_data.degenerate_normal,
        m_data.unit_x == '0 && m_data.unit_y == '0 && m_data.unit_z == '0)
    `VPNT_ASSERT_NEXT(a_row_write_recompute, aclk, aresetn,
        cfg_valid && cfg_ready && (cfg_index == REG_ROW_X || cfg_index == REG_ROW_Y
        || cfg_index == REG_ROW_Z), cof_status.busy)
    `VPNT_ASSERT_NEXT(a_accept_enters, aclk, aresetn, s_valid && s_ready, vld_reg[ST_MUL])

endmodule

// File: sv/vpnt_cofactor.sv
// ---------------------------------------------------------------------------
// Cofactor sequencer
// Recomputes the nine cofactors and the determinant sign of the linear part
// in sequence, with one pair of multipliers for the cofactors and one for the determinant.
// ---------------------------------------------------------------------------
module vpnt_cofactor (
    input  logic                                         aclk,
    input  logic                                         aresetn,
    input  logic                                         start,
    input  logic [2:0][vpnt_pkg::ROW_W-1:0]              rows,
    output logic [vpnt_pkg::COF_N-1:0][vpnt_pkg::COF_W-1:0] cof,
    output vpnt_pkg::cof_status_t                        status
);
    import vpnt_pkg::*;

    typedef enum logic [2:0] {
        SEQ_IDLE = 3'b001,
        SEQ_COF  = 3'b010,
        SEQ_DET  = 3'b100
    } seq_state_t;

    seq_state_t state_reg, state_next;
    logic [3:0] cnt_reg, cnt_next;

    logic signed [MAT_W-1:0]   amat [9];
    logic signed [MAT_W-1:0]   op_a, op_b, op_c, op_d;
    logic signed [MAT_W-1:0]   det_a;
    logic signed [COF_W-1:0]   det_c;
    logic signed [2*MAT_W-1:0] p1_reg, p2_reg;
    logic signed [MAT_W+COF_W-1:0] dprod_reg;
    logic signed [MAT_W+COF_W+1:0] det_reg, det_sum;
    logic det_neg_reg;
    logic [COF_N-1:0][COF_W-1:0] cof_reg;

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                amat[r*3+c] = $signed(rows[r][c*MAT_W +: MAT_W]);
            end
        end
    end

    always_comb begin
        unique case (cnt_reg)
            4'd0: begin op_a = amat[4]; op_b = amat[8]; op_c = amat[5]; op_d = amat[7]; end
            4'd1: begin op_a = amat[5]; op_b = amat[6]; op_c = amat[3]; op_d = amat[8]; end
            4'd2: begin op_a = amat[3]; op_b = amat[7]; op_c = amat[4]; op_d = amat[6]; end
            4'd3: begin op_a = amat[2]; op_b = amat[7]; op_c = amat[1]; op_d = amat[8]; end
            4'd4: begin op_a = amat[0]; op_b = amat[8]; op_c = amat[2]; op_d = amat[6]; end
            4'd5: begin op_a = amat[1]; op_b = amat[6]; op_c = amat[0]; op_d = amat[7]; end
            4'd6: begin op_a = amat[1]; op_b = amat[5]; op_c = amat[2]; op_d = amat[4]; end
            4'd7: begin op_a = amat[2]; op_b = amat[3]; op_c = amat[0]; op_d = amat[5]; end
            4'd8: begin op_a = amat[0]; op_b = amat[4]; op_c = amat[1]; op_d = amat[3]; end
            default: begin op_a = '0; op_b = '0; op_c = '0; op_d = '0; end
        endcase
    end

    always_comb begin
        unique case (cnt_reg)
            4'd0: begin det_a = amat[0]; det_c = $signed(cof_reg[0]); end
            4'd1: begin det_a = amat[1]; det_c = $signed(cof_reg[1]); end
            4'd2: begin det_a = amat[2]; det_c = $signed(cof_reg[2]); end
            default: begin det_a = '0; det_c = '0; end
        endcase
    end

    assign det_sum = det_reg + (MAT_W+COF_W+2)'(dprod_reg);

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        if (start) begin
            state_next = SEQ_COF;
            cnt_next   = '0;
        end else begin
            unique case (state_reg)
                SEQ_IDLE: begin
                    cnt_next = '0;
                end
                SEQ_COF: begin
                    if (cnt_reg == 4'd9) begin
                        state_next = SEQ_DET;
                        cnt_next   = '0;
                    end else begin
                        cnt_next = cnt_reg + 4'd1;
                    end
                end
                SEQ_DET: begin
                    if (cnt_reg == 4'd3) begin
                        state_next = SEQ_IDLE;
                        cnt_next   = '0;
                    end else begin
                        cnt_next = cnt_reg + 4'd1;
                    end
                end
                default: begin
                    state_next = SEQ_IDLE;
                    cnt_next   = '0;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= SEQ_IDLE;
            cnt_reg     <= '0;
            det_neg_reg <= 1'b0;
            for (int e = 0; e < COF_N; e++) begin
                cof_reg[e] <= (e == 0 || e == 4 || e == 8) ? COF_ONE : '0;
            end
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            if (state_reg == SEQ_COF && !start) begin
                for (int e = 0; e < COF_N; e++) begin
                    if (cnt_reg == 4'(e + 1)) begin
                        cof_reg[e] <= COF_W'((2*MAT_W+1)'(p1_reg) - (2*MAT_W+1)'(p2_reg));
                    end
                end
            end
            if (state_reg == SEQ_DET && !start) begin
                if (cnt_reg == 4'd1) begin
                    det_reg <= (MAT_W+COF_W+2)'(dprod_reg);
                end else if (cnt_reg != 4'd0) begin
                    det_reg <= det_sum;
                end
                if (cnt_reg == 4'd3) begin
                    det_neg_reg <= det_sum[MAT_W+COF_W+1];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        p1_reg    <= op_a * op_b;
        p2_reg    <= op_c * op_d;
        dprod_reg <= det_a * det_c;
    end

    assign cof            = cof_reg;
    assign status.busy    = (state_reg != SEQ_IDLE);
    assign status.det_neg = det_neg_reg;

endmodule
